@@ rtl/jbm_pkg.sv @@
// Package for the JSON bracket matcher: byte codes, token classes,
// status codes and the token record passed from the front to the back.
// No dependencies.
`timescale 1ns / 1ps

package jbm_pkg;

  // Default depth of the closer stack
  localparam int JBM_STACK_DEPTH = 64;

  // Depth of the token queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Byte values of interest
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_LCURLY    = 8'h7B;
  localparam logic [7:0] CH_LSQUARE   = 8'h5B;
  localparam logic [7:0] CH_RCURLY    = 8'h7D;
  localparam logic [7:0] CH_RSQUARE   = 8'h5D;

  // Token classes
  localparam logic [2:0] TK_OTHER  = 3'd0;
  localparam logic [2:0] TK_QUOTE  = 3'd1;
  localparam logic [2:0] TK_BSLASH = 3'd2;
  localparam logic [2:0] TK_OPEN   = 3'd3;
  localparam logic [2:0] TK_CLOSE  = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN     = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_UNTERM   = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  // Classified byte, as queued between front and back
  typedef struct packed {
    logic [2:0] cls;           // token class
    logic       square;        // bracket rather than brace, for open/close
    logic       begin_search;
    logic       closer_kind;
    logic       end_of_text;
  } tok_t;

endpackage

@@ rtl/jbm_if.sv @@
// Channel interfaces of the JSON bracket matcher: the byte input channel
// and the result channel, each with valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps

interface jbm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       begin_search;
  logic       closer_kind;
  logic       end_of_text;

  modport source (output valid, text_byte, begin_search, closer_kind, end_of_text,
                  input ready);
  modport sink   (input valid, text_byte, begin_search, closer_kind, end_of_text,
                  output ready);
endinterface

interface jbm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] match_offset;

  modport source (output valid, status, match_offset, input ready);
  modport sink   (input valid, status, match_offset, output ready);
endinterface

@@ rtl/jbm_front.sv @@
// Front of the JSON bracket matcher: accepts bytes and classifies them
// into tokens for the queue. Depends on jbm_pkg and jbm_in_if.
`timescale 1ns / 1ps

module jbm_front
  import jbm_pkg::*;
(
  jbm_in_if.sink in_ch,
  output logic   tok_valid,
  output tok_t   tok,
  input  logic   tok_ready
);

  // Pass the handshake through to the queue
  assign tok_valid   = in_ch.valid;
  assign in_ch.ready = tok_ready;

  // Classify the byte
  always_comb begin
    tok.cls          = TK_OTHER;
    tok.square       = 1'b0;
    tok.begin_search = in_ch.begin_search;
    tok.closer_kind  = in_ch.closer_kind;
    tok.end_of_text  = in_ch.end_of_text;
    case (in_ch.text_byte)
      CH_QUOTE:     tok.cls = TK_QUOTE;
      CH_BACKSLASH: tok.cls = TK_BSLASH;
      CH_LCURLY: begin
        tok.cls = TK_OPEN;
      end
      CH_LSQUARE: begin
        tok.cls    = TK_OPEN;
        tok.square = 1'b1;
      end
      CH_RCURLY: begin
        tok.cls = TK_CLOSE;
      end
      CH_RSQUARE: begin
        tok.cls    = TK_CLOSE;
        tok.square = 1'b1;
      end
      default:      tok.cls = TK_OTHER;
    endcase
  end

endmodule

@@ rtl/jbm_queue.sv @@
// Token queue between the front and the back of the JSON bracket matcher.
// Depends on jbm_pkg.
`timescale 1ns / 1ps

module jbm_queue
  import jbm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  input  tok_t wr_tok,
  output logic wr_ready,
  output logic rd_valid,
  output tok_t rd_tok,
  input  logic rd_ready
);

  tok_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;

  assign wr_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_tok   = q_mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Advance pointers with wrap, track fill
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= wr_tok;
    end
  end

endmodule

@@ rtl/jbm_back.sv @@
// Back of the JSON bracket matcher: string/escape tracking, closer stack,
// offset counter and the result register. Depends on jbm_pkg, jbm_out_if.
`timescale 1ns / 1ps

module jbm_back
  import jbm_pkg::*;
#(
  parameter int STACK_DEPTH = JBM_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       tok_valid,
  input  tok_t       tok,
  output logic       tok_ready,
  jbm_out_if.source  out_ch
);

  localparam int DW = $clog2(STACK_DEPTH + 1);

  // Search state; stack top sits at bit 0
  logic [STACK_DEPTH-1:0] stk_r, stk_nxt, stk_cur;
  logic [DW-1:0]          dep_r, dep_nxt, dep_cur;
  logic                   str_r, str_nxt, str_cur;
  logic                   esc_r, esc_nxt, esc_cur;
  logic                   act_r, act_nxt, act_cur;
  logic [31:0]            cnt_r, cnt_nxt, cnt_cur;

  // Result register
  logic                   out_valid_r, out_valid_nxt;
  logic [2:0]             out_status_r, status_nxt;
  logic [31:0]            out_offset_r, offset_nxt;

  logic                   fire;

  assign tok_ready = !out_valid_r || out_ch.ready;
  assign fire      = tok_valid && tok_ready;

  // Seed a fresh search on begin, else carry the stored state
  always_comb begin
    if (tok.begin_search) begin
      stk_cur = STACK_DEPTH'(tok.closer_kind);
      dep_cur = DW'(1);
      str_cur = 1'b0;
      esc_cur = 1'b0;
      act_cur = 1'b1;
      cnt_cur = '0;
    end else begin
      stk_cur = stk_r;
      dep_cur = dep_r;
      str_cur = str_r;
      esc_cur = esc_r;
      act_cur = act_r;
      cnt_cur = cnt_r;
    end
  end

  // Execute one token
  always_comb begin
    stk_nxt    = stk_cur;
    dep_nxt    = dep_cur;
    str_nxt    = str_cur;
    esc_nxt    = esc_cur;
    act_nxt    = act_cur;
    cnt_nxt    = cnt_cur;
    status_nxt = ST_IDLE;
    offset_nxt = '0;
    if (act_cur) begin
      status_nxt = ST_SCAN;
      offset_nxt = cnt_cur;
      cnt_nxt    = (cnt_cur == '1) ? cnt_cur : cnt_cur + 32'd1;
      if (str_cur) begin
        // Inside a string: only quote and backslash matter
        if (tok.cls == TK_BSLASH) begin
          esc_nxt = !esc_cur;
        end else if (tok.cls == TK_QUOTE && !esc_cur) begin
          str_nxt = 1'b0;
        end else begin
          esc_nxt = 1'b0;
        end
      end else begin
        case (tok.cls)
          TK_QUOTE: begin
            str_nxt = 1'b1;
            esc_nxt = 1'b0;
          end
          TK_OPEN: begin
            if (dep_cur == DW'(STACK_DEPTH)) begin
              status_nxt = ST_OVERFLOW;
            end else begin
              stk_nxt = (stk_cur << 1) | STACK_DEPTH'(tok.square);
              dep_nxt = dep_cur + 1'b1;
            end
          end
          TK_CLOSE: begin
            if (dep_cur == '0 || stk_cur[0] != tok.square) begin
              status_nxt = ST_MISMATCH;
            end else begin
              stk_nxt = stk_cur >> 1;
              dep_nxt = dep_cur - 1'b1;
              if (dep_cur == DW'(1)) begin
                status_nxt = ST_FOUND;
              end
            end
          end
          default: begin
          end
        endcase
      end
      // End of text without a verdict
      if (status_nxt == ST_SCAN && tok.end_of_text) begin
        status_nxt = ST_UNTERM;
      end
      if (status_nxt != ST_SCAN) begin
        act_nxt = 1'b0;
      end
    end
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stk_r       <= '0;
      dep_r       <= '0;
      str_r       <= 1'b0;
      esc_r       <= 1'b0;
      act_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        stk_r <= stk_nxt;
        dep_r <= dep_nxt;
        str_r <= str_nxt;
        esc_r <= esc_nxt;
        act_r <= act_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= status_nxt;
      out_offset_r <= offset_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.match_offset = out_offset_r;

endmodule

@@ rtl/json_bracket_matcher.sv @@
// A result is registered: its byte passes through the queue, then the result register.
// Throughput: one byte per cycle while out_ch is ready; the back executes one queued token per
// cycle and the closer stack is a shift register whose top is always at hand.
// Reset: synchronous active-low rst_n empties the queue, drops any pending result and
// clears the search state (no active search, empty stack, offset zero).
// Top level; depends on jbm_pkg, jbm_if, jbm_front, jbm_queue and jbm_back.
`timescale 1ns / 1ps

module json_bracket_matcher
  import jbm_pkg::*;
#(
  parameter int STACK_DEPTH = JBM_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  jbm_in_if.sink     in_ch,
  jbm_out_if.source  out_ch
);

  logic f_valid, f_ready;
  tok_t f_tok;
  logic q_valid, q_ready;
  tok_t q_tok;

  // Classify incoming bytes
  jbm_front u_front (
    .in_ch     (in_ch),
    .tok_valid (f_valid),
    .tok       (f_tok),
    .tok_ready (f_ready)
  );

  // Decouple front and back
  jbm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_tok   (f_tok),
    .wr_ready (f_ready),
    .rd_valid (q_valid),
    .rd_tok   (q_tok),
    .rd_ready (q_ready)
  );

  // Execute tokens and produce results
  jbm_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (q_valid),
    .tok       (q_tok),
    .tok_ready (q_ready),
    .out_ch    (out_ch)
  );

`ifndef ASSERT_OFF
  // An idle answer carries a zero offset
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_IDLE |-> out_ch.match_offset == 32'd0)
    else $error("idle result with nonzero offset");

  // Status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.status <= ST_OVERFLOW)
    else $error("undefined status code");

  // Input is held off only while the queue has work
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_valid)
    else $error("input stalled with empty queue");

  // No result right after reset
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid after reset");
`endif

endmodule
